// ----- rtl/core/sida_pkg.sv -----
package sida_pkg;

   // ASCII codes of the emitted characters, cut to the character width
   localparam int CHAR_WIDTH  = 6;
   localparam int DIGIT_WIDTH = 4;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

   // Fill status of the queue between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_SIGN,
      BACK_DIGITS
   } back_state_type;

endpackage

// ----- rtl/core/sida_front.sv -----
module sida_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  sida_pkg::queue_status_type    q_status,
   output logic                          push,
   output logic [VALUE_WIDTH:0]          push_data
);
   import sida_pkg::*;

   logic                   hold_valid_ff, hold_valid_in;
   logic                   hold_neg_ff, hold_neg_in;
   logic [VALUE_WIDTH-1:0] hold_mag_ff, hold_mag_in;
   logic                   accept;

   // Hand the held item to the queue whenever it has room
   assign push      = hold_valid_ff && !q_status.full;
   assign req_stall = hold_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push_data = {hold_neg_ff, hold_mag_ff};

   // Classify the sign and form the unsigned magnitude
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_neg_in   = hold_neg_ff;
      hold_mag_in   = hold_mag_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_neg_in   = req_value[VALUE_WIDTH-1];
         hold_mag_in   = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_neg_ff <= hold_neg_in;
      hold_mag_ff <= hold_mag_in;
   end

endmodule

// ----- rtl/core/sida_queue.sv -----
module sida_queue #(
   parameter int DATA_WIDTH = 33
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [DATA_WIDTH-1:0]        push_data,
   input  logic                         pop,
   output logic [DATA_WIDTH-1:0]        pop_data,
   output sida_pkg::queue_status_type   q_status
);
   import sida_pkg::*;

   logic [DATA_WIDTH-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;

   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);
   assign pop_data       = entry_ff[rd_ptr_ff];

   // Advance pointers and track fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/sida_back.sv -----
module sida_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sida_pkg::queue_status_type          q_status,
   input  logic [VALUE_WIDTH:0]                pop_data,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sida_pkg::CHAR_WIDTH-1:0]     rsp_character,
   output logic                                rsp_last
);
   import sida_pkg::*;

   localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
   localparam int BCD_WIDTH  = NUM_DIGITS * DIGIT_WIDTH;
   localparam int CNT_WIDTH  = $clog2(VALUE_WIDTH);
   localparam int IDX_WIDTH  = $clog2(NUM_DIGITS);

   back_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;
   logic                   neg_ff, neg_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   out_free;
   logic [DIGIT_WIDTH-1:0] top_digit;
   logic [DIGIT_WIDTH-1:0] digit;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign top_digit     = bcd_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];

   // Add three to every BCD digit of five or more before the shift
   always_comb begin
      digit = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digit = bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH];
         bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] = (digit >= 4'd5) ? digit + 4'd3 : digit;
      end
   end

   // Sequence: load, shift-add-3 over all bits, sign, then digits
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               pop        = 1'b1;
               neg_in     = pop_data[VALUE_WIDTH];
               bin_in     = pop_data[VALUE_WIDTH-1:0];
               bcd_in     = '0;
               cnt_in     = '0;
               started_in = 1'b0;
               state_in   = BACK_CONVERT;
            end
         end
         BACK_CONVERT: begin
            bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
               idx_in   = IDX_WIDTH'(NUM_DIGITS - 1);
               state_in = BACK_SIGN;
            end
         end
         BACK_SIGN: begin
            if (!neg_ff) begin
               state_in = BACK_DIGITS;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = BACK_DIGITS;
            end
         end
         BACK_DIGITS: begin
            // drop leading zeros, keep the units digit always
            if (!started_ff && top_digit == '0 && idx_ff != '0) begin
               bcd_in = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
               idx_in = idx_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, top_digit};
               rsp_last_in  = (idx_ff == '0);
               started_in   = 1'b1;
               bcd_in       = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
               if (idx_ff == '0) begin
                  state_in = BACK_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      started_ff  <= started_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// Channel   | Ports                               | Direction
// ----------+-------------------------------------+----------
// request   | req_valid, req_stall, req_value     | in
// response  | rsp_valid, rsp_stall, rsp_character,| out
//           | rsp_last                            |
//
// Each item is loaded, then converted by shift-add-3 over all VALUE_WIDTH bits in the
// back end, then given its sign if negative and one decimal digit position at a time
// (leading zeros skipped at one per cycle).
// A front register and a two-entry queue take up to three further items meanwhile.
// Reset is synchronous and clears the queue, the sequencer and the valid flags.
// A stalled response holds its character; conversion pauses only on output.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [VALUE_WIDTH-1:0]    req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sida_pkg::CHAR_WIDTH-1:0]  rsp_character,
   output logic                             rsp_last
);
   import sida_pkg::*;

   queue_status_type     q_status;
   logic                 push;
   logic                 pop;
   logic [VALUE_WIDTH:0] push_data;
   logic [VALUE_WIDTH:0] pop_data;

   sida_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   sida_queue #(
      .DATA_WIDTH (VALUE_WIDTH + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   sida_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .pop_data      (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- tb/tb_signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;
   import sida_pkg::*;

   localparam int VALUE_WIDTH   = 32;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 130;
   localparam int HOLD_AFTER    = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 200;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [VALUE_WIDTH-1:0] DECIMAL_BASE = 10;

   // One character of the expected decimal text
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } text_char_type;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [CHAR_WIDTH-1:0]         rsp_character;
   logic                          rsp_last;

   logic signed [VALUE_WIDTH-1:0] pending_values[$];
   text_char_type                 expected_text[$];
   int                            items_accepted = 0;
   int                            mismatch_count = 0;
   int                            quiet_cycles = 0;
   int                            gap_left = 0;
   int                            burst_left = 0;
   int                            hold_left = 0;
   bit                            hold_done = 1'b0;
   int                            mode_left = 0;
   stall_mode_type                stall_mode = STALL_NONE;

   signed_int_to_decimal_ascii #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Append the decimal text of one value, sign first, most significant digit next
   function automatic void expand_decimal_text(input logic signed [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [DIGIT_WIDTH-1:0] digit_stack[24];
      int                     digit_count;
      int                     k;
      text_char_type          entry;
      magnitude = value;
      if (value[VALUE_WIDTH-1]) begin
         magnitude = ~magnitude + 1'b1;
      end
      digit_count = 0;
      if (magnitude == 0) begin
         digit_stack[0] = '0;
         digit_count = 1;
      end
      while (magnitude != 0) begin
         digit_stack[digit_count] = DIGIT_WIDTH'(magnitude % DECIMAL_BASE);
         magnitude = magnitude / DECIMAL_BASE;
         digit_count++;
      end
      if (value[VALUE_WIDTH-1]) begin
         entry.character = CHAR_MINUS;
         entry.last = 1'b0;
         expected_text.push_back(entry);
      end
      for (k = digit_count - 1; k >= 0; k--) begin
         entry.character = CHAR_ZERO + CHAR_WIDTH'(digit_stack[k]);
         entry.last = (k == 0);
         expected_text.push_back(entry);
      end
   endfunction

   // Draw a value, weighted toward digit-count and range boundaries
   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      longint magnitude;
      longint low_bound;
      int     digits;
      int     k;
      bit     negative;
      negative = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            return $urandom;
         end
         3, 4, 5: begin
            digits = $urandom_range(1, 10);
            low_bound = 1;
            for (k = 1; k < digits; k++) begin
               low_bound = low_bound * 10;
            end
            magnitude = low_bound + ({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff)
                        % (low_bound * 9);
            if (digits == 1) begin
               magnitude = $urandom_range(0, 9);
            end
         end
         6, 7: begin
            digits = $urandom_range(1, 9);
            magnitude = 1;
            for (k = 0; k < digits; k++) begin
               magnitude = magnitude * 10;
            end
            magnitude = magnitude + $urandom_range(0, 2) - 1;
         end
         8: begin
            magnitude = 64'd2147483648 - $urandom_range(0, 9);
         end
         default: begin
            magnitude = $urandom_range(0, 20);
         end
      endcase
      if (negative) begin
         if (magnitude > 64'd2147483648) begin
            magnitude = 64'd2147483648;
         end
         return VALUE_WIDTH'(-magnitude);
      end
      if (magnitude > 64'd2147483647) begin
         magnitude = 64'd2147483647;
      end
      return VALUE_WIDTH'(magnitude);
   endfunction

   // Feed pending items in bursts; hold a stalled item unchanged
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
         gap_left = 0;
         burst_left = $urandom_range(1, 8);
      end else begin
         if (req_valid && !req_stall) begin
            expand_decimal_text(req_value);
            void'(pending_values.pop_front());
            items_accepted <= items_accepted + 1;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_values.size() > 0) begin
            req_valid <= 1'b1;
            req_value <= pending_values[0];
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 8);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side; one long hold-off lets the block fill up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && items_accepted >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:     rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Compare each accepted character with the oldest expected one
   always @(posedge clock) begin
      text_char_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_text.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected character %0d last %0b", $realtime,
                        rsp_character, rsp_last);
            end
         end else begin
            wanted = expected_text.pop_front();
            if (wanted.character !== rsp_character || wanted.last !== rsp_last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: character expected %0d last %0b, got %0d last %0b",
                           $realtime, wanted.character, wanted.last,
                           rsp_character, rsp_last);
               end
            end
         end
      end
   end

   // Drop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Directed: zero, single digits, digit-count edges, both extremes
      pending_values.push_back(32'sd0);
      pending_values.push_back(32'sd1);
      pending_values.push_back(-32'sd1);
      pending_values.push_back(32'sd9);
      pending_values.push_back(32'sd10);
      pending_values.push_back(-32'sd10);
      pending_values.push_back(32'sd99);
      pending_values.push_back(32'sd100);
      pending_values.push_back(-32'sd7);
      pending_values.push_back(32'sd1234567890);
      pending_values.push_back(-32'sd987654321);
      pending_values.push_back(32'sd999999999);
      pending_values.push_back(32'sd1000000000);
      pending_values.push_back(-32'sd999999999);
      pending_values.push_back(-32'sd1000000000);
      pending_values.push_back(32'sh7fff_ffff);
      pending_values.push_back(32'sh8000_0000);
      pending_values.push_back(32'sh8000_0001);
      pending_values.push_back(32'sh5555_5555);
      pending_values.push_back(32'shaaaa_aaaa);
      repeat (RANDOM_ITEMS) begin
         pending_values.push_back(random_value());
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for all items to go in and all text to come out, then drain
      while (pending_values.size() != 0 || req_valid) @(posedge clock);
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/sida_pkg.sv
rtl/core/sida_front.sv
rtl/core/sida_queue.sv
rtl/core/sida_back.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/tb_signed_int_to_decimal_ascii.sv
